>>> hw/rtl/dlu_pkg.sv
// Types and constants shared by the LU decomposition block.
package dlu_pkg;

  localparam int DataW = 32;
  localparam int AccW  = 64;
  localparam int IdxW  = 2;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } dlu_state_t;

  localparam logic [0:0] RegSize = 1'b0;

endpackage

>>> hw/rtl/dlu_div.sv
// Iterative restoring divider with rounding to nearest and saturation.
module dlu_div import dlu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AccW-1:0]  num,
  input  logic signed [DataW-1:0] den,
  output logic                    done,
  output logic signed [DataW-1:0] quot
);

  logic [AccW-1:0]  rem_r, rem_nxt;
  logic [AccW-1:0]  q_r, q_nxt;
  logic [DataW-1:0] md_r, md_nxt;
  logic             neg_r, neg_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AccW-1:0]  mn;
  logic [DataW-1:0] md;
  logic [AccW:0]    trial;
  logic [AccW:0]    sum_in;

  assign mn = num[AccW-1] ? (~num + 1'b1) : num;
  assign md = den[DataW-1] ? (~den + 1'b1) : den;
  assign sum_in = {1'b0, mn} + {33'd0, 1'b0, md[DataW-1:1]};
  assign trial = {rem_r, q_r[AccW-1]} - {{(AccW-DataW+1){1'b0}}, md_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    md_nxt   = md_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = sum_in[AccW] ? {AccW{1'b1}} : sum_in[AccW-1:0];
      md_nxt   = md;
      neg_nxt  = num[AccW-1] ^ den[DataW-1];
      cnt_nxt  = 7'(AccW + 1);
      busy_nxt = 1'b1;
      if (sum_in[AccW]) begin
        cnt_nxt  = '0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!trial[AccW]) begin
        rem_nxt = trial[AccW-1:0];
        q_nxt   = {q_r[AccW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[AccW-2:0], q_r[AccW-1]};
        q_nxt   = {q_r[AccW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 7'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    md_r  <= md_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (!neg_r) begin
      quot = (q_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_r[DataW-1:0];
    end else begin
      quot = (q_r >= 64'h8000_0000) ? 32'sh8000_0000 : (~q_r[DataW-1:0] + 1'b1);
    end
  end

  assign done = done_r;

endmodule

>>> hw/rtl/doolittle_lu_decomposition.sv
// Top level of the Doolittle LU decomposition block.
// Channel | Dir | Signals
// in      | in  | in_valid, in_ready, in_element_value
// out     | out | out_valid, out_ready, out_row/col_index, out_lower/upper_value, flags
// cfg     | in  | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata, cfg_prdata
// Loading takes one element per handshake. Factoring runs one multiply-accumulate
// per cycle through a single 32x32 multiplier and 64-bit saturating adder; each L entry
// with a nonzero pivot adds a bit-serial division. Results leave one per transfer.
// Reset is synchronous; input is not ready while factoring or emitting.
module doolittle_lu_decomposition import dlu_pkg::*; #(
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DataW-1:0] in_element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IdxW-1:0]         out_row_index,
  output logic [IdxW-1:0]         out_col_index,
  output logic signed [DataW-1:0] out_lower_value,
  output logic signed [DataW-1:0] out_upper_value,
  output logic                    out_zero_pivot,
  output logic                    out_last_of_run,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [1:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(Depth + 1);

  dlu_state_t state_r, state_nxt;
  logic [2:0]    size_reg_r;
  logic [DW-1:0] n_eff;
  logic [CW-1:0] total, load_cnt_r;
  logic [DW-1:0] i_r, j_r, k_r;
  logic [CW-1:0] emit_r;
  logic          perr_r;
  logic signed [DataW-1:0] a_mem [Depth];
  logic signed [DataW-1:0] l_mem [Depth];
  logic signed [DataW-1:0] u_mem [Depth];
  logic signed [AccW-1:0]  acc_r;
  logic signed [DataW-1:0] lop_r, uop_r, piv_r, a_rd_r;
  logic signed [2*DataW-1:0] prod_r;
  logic          prod_v_r;
  logic          mul_v_r;
  logic signed [AccW:0] sum;
  logic signed [AccW-1:0] sum_sat;
  logic          div_start, div_done;
  logic signed [DataW-1:0] div_q;
  logic [AccW-1:0] mag, rnd;
  logic signed [DataW-1:0] u_round;
  logic [2*DW-1:0] lin_ij, lin_ik, lin_kj, lin_jj;
  logic            cfg_wr;
  logic            load_last;
  logic            emit_go;
  logic            out_v_r;
  logic [IdxW-1:0] orow_r, ocol_r;
  logic signed [DataW-1:0] olo_r, oup_r;
  logic            olast_r;
  logic [DW-1:0]   er_r, ec_r;

  always_comb begin
    if (size_reg_r == 3'd0) n_eff = DW'(1);
    else if (32'(size_reg_r) > MAX_DIM) n_eff = DW'(MAX_DIM);
    else n_eff = DW'(size_reg_r);
  end
  assign total  = CW'(n_eff) * CW'(n_eff);
  assign lin_ij = (2*DW)'(i_r) * (2*DW)'(n_eff) + (2*DW)'(j_r);
  assign lin_ik = (2*DW)'(i_r) * (2*DW)'(n_eff) + (2*DW)'(k_r);
  assign lin_kj = (2*DW)'(k_r) * (2*DW)'(n_eff) + (2*DW)'(j_r);
  assign lin_jj = (2*DW)'(j_r) * (2*DW)'(n_eff) + (2*DW)'(j_r);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {29'd0, size_reg_r} : 32'd0;

  assign in_ready = (state_r == ST_LOAD);

  assign load_last = (load_cnt_r >= total) ? (total == CW'(1))
                                           : (load_cnt_r + 1'b1 == total);
  assign emit_go   = (state_r == ST_EMIT) && (!out_v_r || out_ready) && (emit_r != total);

  assign sum = {acc_r[AccW-1], acc_r} - {prod_r[2*DataW-1], prod_r};
  always_comb begin
    if (sum[AccW] != sum[AccW-1]) sum_sat = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                                     : {1'b0, {(AccW-1){1'b1}}};
    else sum_sat = sum[AccW-1:0];
  end

  assign mag = acc_r[AccW-1] ? (~acc_r + 1'b1) : acc_r;
  assign rnd = (mag + (AccW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  always_comb begin
    if (!acc_r[AccW-1]) u_round = (rnd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : rnd[DataW-1:0];
    else u_round = (rnd >= 64'h8000_0000) ? 32'sh8000_0000 : (~rnd[DataW-1:0] + 1'b1);
  end

  assign div_start = (state_r == ST_ACC) && (j_r < i_r) && (piv_r != 0);

  dlu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_r), .den(piv_r),
    .done(div_done), .quot(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_valid && load_last)
                 state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_MAC;
      ST_MAC:  if (!prod_v_r && ((j_r >= i_r) ? k_r >= i_r : k_r >= j_r))
                 state_nxt = ST_ACC;
      ST_ACC:  state_nxt = div_start ? ST_DIV : ST_WB;
      ST_DIV:  if (div_done) state_nxt = ST_WB;
      ST_WB:   state_nxt = ((i_r == n_eff - 1'b1) && (j_r == n_eff - 1'b1)) ? ST_EMIT : ST_INIT;
      ST_EMIT: if ((emit_r == total) && !out_v_r) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      size_reg_r <= 3'd4;
      load_cnt_r <= '0;
      perr_r     <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0;
      emit_r     <= '0;
      prod_v_r   <= 1'b0;
      mul_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == 2'd0) begin
        size_reg_r <= cfg_pwdata[2:0];
        load_cnt_r <= '0;
      end else if (in_valid && in_ready) begin
        if (load_cnt_r >= total) load_cnt_r <= (total == CW'(1)) ? '0 : CW'(1);
        else if (load_cnt_r + 1'b1 == total) load_cnt_r <= '0;
        else load_cnt_r <= load_cnt_r + 1'b1;
        if (state_nxt == ST_INIT) begin
          i_r <= '0; j_r <= '0;
        end
      end
      if (emit_go) out_v_r <= 1'b1;
      else if (out_v_r && out_ready) out_v_r <= 1'b0;
      unique case (state_r)
        ST_INIT: begin
          k_r <= '0;
          prod_v_r <= 1'b0;
          mul_v_r  <= 1'b0;
        end
        ST_MAC: begin
          prod_v_r <= (j_r >= i_r) ? (k_r < i_r) : (k_r < j_r);
          mul_v_r  <= prod_v_r;
          if ((j_r >= i_r) ? (k_r < i_r) : (k_r < j_r)) k_r <= k_r + 1'b1;
        end
        ST_ACC: if ((j_r < i_r) && (piv_r == 0)) perr_r <= 1'b1;
        ST_WB: begin
          if (j_r == n_eff - 1'b1) begin
            j_r <= '0; i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
          if (state_nxt == ST_EMIT) begin
            emit_r <= '0; er_r <= '0; ec_r <= '0;
          end
        end
        ST_EMIT: if (emit_go) begin
          emit_r  <= emit_r + 1'b1;
          if (ec_r == n_eff - 1'b1) begin
            ec_r <= '0; er_r <= er_r + 1'b1;
          end else ec_r <= ec_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) a_mem[load_cnt_r >= total ? '0 : load_cnt_r[AW-1:0]] <= in_element_value;
    a_rd_r <= a_mem[lin_ij[AW-1:0]];
    lop_r  <= l_mem[lin_ik[AW-1:0]];
    uop_r  <= u_mem[lin_kj[AW-1:0]];
    piv_r  <= u_mem[lin_jj[AW-1:0]];
    prod_r <= lop_r * uop_r;
    if (state_r == ST_MAC) begin
      if (k_r == '0 && !prod_v_r) acc_r <= AccW'(a_rd_r) <<< FRAC_BITS;
      else if (mul_v_r) acc_r <= sum_sat;
    end
    if (state_r == ST_WB) begin
      if (j_r >= i_r) begin
        u_mem[lin_ij[AW-1:0]] <= u_round;
        l_mem[lin_ij[AW-1:0]] <= (j_r == i_r) ? DataW'(1 << FRAC_BITS) : '0;
      end else begin
        u_mem[lin_ij[AW-1:0]] <= '0;
        l_mem[lin_ij[AW-1:0]] <= (piv_r == 0) ? '0 : div_q;
      end
    end
    if (emit_go) begin
      orow_r  <= er_r[IdxW-1:0];
      ocol_r  <= ec_r[IdxW-1:0];
      olo_r   <= l_mem[emit_r[AW-1:0]];
      oup_r   <= u_mem[emit_r[AW-1:0]];
      olast_r <= (emit_r + 1'b1 == total);
    end
  end

  assign out_valid       = out_v_r;
  assign out_row_index   = orow_r;
  assign out_col_index   = ocol_r;
  assign out_lower_value = olo_r;
  assign out_upper_value = oup_r;
  assign out_zero_pivot  = perr_r;
  assign out_last_of_run = olast_r;

endmodule

>>> hw/rtl/dlu_checker.sv
// Port-level assertions for the LU decomposition block, with bind.
module dlu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_zero_pivot,
  input logic        out_last_of_run,
  input logic [31:0] out_lower_value
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lower_value))
    else $error("result dropped");
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_zero_pivot) |-> out_zero_pivot)
    else $error("pivot flag cleared");
  a_last_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> !out_valid)
    else $error("result after last");
endmodule

bind doolittle_lu_decomposition dlu_checker u_dlu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_zero_pivot(out_zero_pivot),
  .out_last_of_run(out_last_of_run), .out_lower_value(out_lower_value)
);
